// ===== rtl/ric_pkg.sv =====
// Shared types, codes and CRC helpers for the ROM image CRC checker.
// No dependencies; every other file imports this package.
package ric_pkg;

  localparam int unsigned PosW     = 17;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] REG_CRC_SEED    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER_CODE = 8'd1;

  localparam logic [15:0] CRC_MASK         = 16'hffff;
  localparam logic [15:0] HEADER_CODE_INIT = 16'h55aa;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
  localparam logic [1:0] STATUS_NO_HEADER = 2'd2;

  // Role of a byte within the trailer words
  typedef enum logic [2:0] {
    ROLE_NONE,
    ROLE_CRC_LO,
    ROLE_CRC_HI,
    ROLE_HDR_LO,
    ROLE_HDR_HI
  } role_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        image_start;
    logic        crc_en;
    role_t       role;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] computed_crc;
    logic [15:0] stored_crc;
    logic [15:0] image_length;
    logic [15:0] header_word;
  } result_t;

  function automatic logic [15:0] nib_tab(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'h0: v = 16'h0000;
      4'h1: v = 16'h1081;
      4'h2: v = 16'h2102;
      4'h3: v = 16'h3183;
      4'h4: v = 16'h4204;
      4'h5: v = 16'h5285;
      4'h6: v = 16'h6306;
      4'h7: v = 16'h7387;
      4'h8: v = 16'h8408;
      4'h9: v = 16'h9489;
      4'ha: v = 16'ha50a;
      4'hb: v = 16'hb58b;
      4'hc: v = 16'hc60c;
      4'hd: v = 16'hd68d;
      4'he: v = 16'he70e;
      default: v = 16'hf78f;
    endcase
    return v;
  endfunction

  // Reflected CRC-16 (0x8408), low nibble first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] c1;
    c1 = nib_tab(c[3:0] ^ b[3:0]) ^ (c >> 4);
    return nib_tab(c1[3:0] ^ b[7:4]) ^ (c1 >> 4);
  endfunction

endpackage

// ===== rtl/ric_if.sv =====
// Handshake channel interfaces for the ROM image CRC checker.
// Depends on ric_pkg for the configuration index width.
interface ric_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;
  modport source (output valid, data_byte, image_start, input ready);
  modport sink (input valid, data_byte, image_start, output ready);
endinterface

interface ric_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] computed_crc;
  logic [15:0] stored_crc;
  logic [15:0] image_length;
  logic [15:0] header_word;
  modport source (output valid, status, computed_crc, stored_crc, image_length,
                  header_word, input ready);
  modport sink (input valid, status, computed_crc, stored_crc, image_length,
                header_word, output ready);
endinterface

interface ric_cfg_if import ric_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [15:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ric_front.sv =====
// Front end: accepts image bytes, tracks position and length, tags each byte
// with its CRC enable and trailer role. Depends on ric_pkg and ric_if.
module ric_front import ric_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ric_byte_if.sink  byte_in,
  input  logic      q_full,
  output logic      push,
  output entry_t    push_entry
);

  logic            run;
  logic [PosW-1:0] pos;
  logic [15:0]     len;

  logic [PosW-1:0] pos_cur;
  logic [15:0]     len_cur;
  logic [15:0]     len_upd;
  logic [PosW-1:0] crc_end;
  logic [PosW-1:0] s_pos;
  logic            accept;
  role_t           role;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_comb begin
    pos_cur = byte_in.image_start ? '0 : pos;
    len_cur = byte_in.image_start ? '0 : len;
    if (pos_cur == PosW'(0)) begin
      len_upd = {len_cur[15:8], byte_in.data_byte};
    end else if (pos_cur == PosW'(1)) begin
      len_upd = {byte_in.data_byte, len_cur[7:0]};
    end else begin
      len_upd = len_cur;
    end
    crc_end = {1'b0, len_upd} + PosW'(1);
    // An odd length rounds down, so the CRC range overlaps the stored word
    s_pos   = {1'b0, len_upd[15:1], 1'b0} + PosW'(2);
    role    = ROLE_NONE;
    if (pos_cur >= PosW'(2)) begin
      if (pos_cur == s_pos) begin
        role = ROLE_CRC_LO;
      end else if (pos_cur == s_pos + PosW'(1)) begin
        role = ROLE_CRC_HI;
      end else if (pos_cur == s_pos + PosW'(2)) begin
        role = ROLE_HDR_LO;
      end else if (pos_cur == s_pos + PosW'(3)) begin
        role = ROLE_HDR_HI;
      end
    end
  end

  assign push = accept && (byte_in.image_start || run);

  always_comb begin
    push_entry.data_byte   = byte_in.data_byte;
    push_entry.image_start = byte_in.image_start;
    push_entry.crc_en      = (pos_cur < PosW'(2)) || (pos_cur <= crc_end);
    push_entry.role        = role;
    push_entry.length      = len_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pos <= '0;
      len <= '0;
    end else if (push) begin
      pos <= pos_cur + PosW'(1);
      len <= len_upd;
      // stop forwarding once the header word is complete
      run <= (role != ROLE_HDR_HI);
    end
  end

endmodule

// ===== rtl/ric_queue.sv =====
// Two-entry queue of tagged bytes between the front and back ends.
// Depends on ric_pkg for the entry type and depth.
module ric_queue import ric_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   q_valid,
  output logic   q_full,
  output entry_t q_head
);

  entry_t           slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == QCntW'(QDepth));
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/ric_back.sv =====
// Back end: runs the CRC, captures trailer words, decides the verdict and
// holds it in the output register. Depends on ric_pkg and ric_if.
module ric_back import ric_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  entry_t        q_head,
  output logic          pop,
  input  logic [15:0]   crc_seed,
  input  logic [15:0]   header_code,
  ric_result_if.source  result_out
);

  logic        run;
  logic [15:0] crc;
  logic [7:0]  low_hold;
  logic [15:0] captured;
  logic        out_valid;
  result_t     out_res;

  logic        active;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic [15:0] word;
  logic [15:0] final_crc;
  logic        emit;
  logic        finish;
  result_t     res;

  assign pop    = q_valid && (!out_valid || result_out.ready);
  assign active = q_head.image_start || run;

  always_comb begin
    crc_base  = q_head.image_start ? (crc_seed ^ CRC_MASK) : crc;
    crc_new   = (active && q_head.crc_en) ? crc_byte(crc_base, q_head.data_byte) : crc_base;
    final_crc = crc_new ^ CRC_MASK;
    word      = {q_head.data_byte, low_hold};
    emit      = 1'b0;
    finish    = 1'b0;
    res.status       = STATUS_OK;
    res.computed_crc = final_crc;
    res.stored_crc   = captured;
    res.image_length = q_head.length;
    res.header_word  = word;
    if (active) begin
      unique case (q_head.role)
        ROLE_CRC_HI: begin
          res.stored_crc  = word;
          res.status      = STATUS_CRC_ERR;
          res.header_word = '0;
          if (word != final_crc) begin
            emit   = 1'b1;
            finish = 1'b1;
          end
        end
        ROLE_HDR_HI: begin
          emit       = 1'b1;
          finish     = 1'b1;
          res.status = (word == header_code) ? STATUS_OK : STATUS_NO_HEADER;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && active) begin
      crc <= crc_new;
      case (q_head.role) inside
        ROLE_CRC_LO, ROLE_HDR_LO: low_hold <= q_head.data_byte;
        ROLE_CRC_HI:              captured <= word;
        default: begin
        end
      endcase
    end
    if (pop && emit) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && active) begin
        run <= !finish;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.status       = out_res.status;
  assign result_out.computed_crc = out_res.computed_crc;
  assign result_out.stored_crc   = out_res.stored_crc;
  assign result_out.image_length = out_res.image_length;
  assign result_out.header_word  = out_res.header_word;

endmodule

// ===== rtl/rom_image_crc_checker.sv =====
// Checks a ROM image streamed one byte per cycle unless input stalls: a byte
// with image_start set begins an image, the little-endian length L opens it,
// a reflected CRC-16 (0x8408, complemented in and out) covers bytes 0 to L+1,
// and the stored CRC and header word follow at offset 2*floor(L/2)+2. The
// block takes one byte every cycle until its queue fills; each byte passes
// the front end (position and role tagging) into a two-entry queue and then
// the back end, whose two-nibble CRC update sets the rate. A verdict passes
// the queue and the output register after its last byte is accepted and is
// held until taken; while it waits the back end stalls, and the queue takes
// up to two more bytes before input stalls. Configuration writes are always
// ready. Depends on ric_pkg, ric_if, ric_front, ric_queue and ric_back.
module rom_image_crc_checker import ric_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ric_byte_if.sink     byte_in,
  ric_result_if.source result_out,
  ric_cfg_if.sink      cfg
);

  logic [15:0] crc_seed;
  logic [15:0] header_code;

  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_valid;
  logic   q_full;
  entry_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed    <= '0;
      header_code <= HEADER_CODE_INIT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_CRC_SEED:    crc_seed    <= cfg.data;
        REG_HEADER_CODE: header_code <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  ric_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ric_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .q_head     (q_head)
  );

  ric_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .crc_seed    (crc_seed),
    .header_code (header_code),
    .result_out  (result_out)
  );

  // A mismatch verdict never carries a header word
  a_err_no_header: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status == STATUS_CRC_ERR) |-> result_out.header_word == '0)
    else $error("CRC error result carries a header word");

  // Only a matching CRC lets a header verdict through
  a_ok_crc_match: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status != STATUS_CRC_ERR)
      |-> result_out.computed_crc == result_out.stored_crc)
    else $error("header verdict reported despite CRC mismatch");

  // An ok verdict means the header word matched the programmed code
  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status == STATUS_OK) |-> result_out.header_word == header_code)
    else $error("ok verdict with wrong header word");

  // Queue never overflows: a push into a full queue must pop in the same cycle
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_full || pop))
    else $error("queue overflow");

endmodule
